// ===== rtl/numeric_literal_parser_macros.svh =====
// ----------------------------------------------------------------------------
// numeric literal parser assertion macros
// clocked assertion wrappers shared by the checker
// ----------------------------------------------------------------------------
`ifndef NUMERIC_LITERAL_PARSER_MACROS_SVH
`define NUMERIC_LITERAL_PARSER_MACROS_SVH

// clocked property with asynchronous reset disable
`define NLP_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("nlp assertion failed");

// stalled valid keeps its payload
`define NLP_ASSERT_HOLD(label, clk, rst_n, vld, rdy, sig) \
	`NLP_ASSERT(label, clk, rst_n, vld && !rdy |=> vld && $stable(sig))

`endif

// ===== rtl/nlp_pkg.sv =====
// ----------------------------------------------------------------------------
// nlp_pkg
// types, character codes and helpers of the numeric literal parser
// ----------------------------------------------------------------------------
package nlp_pkg;

	localparam int VALUE_WIDTH_DEF = 64;
	localparam int OUT_WIDTH = 64;
	localparam int CH_WIDTH = 8;
	localparam int DIG_WIDTH = 7;

	typedef enum logic [2:0] {
		PH_SIGN    = 3'd0,
		PH_LEAD    = 3'd1,
		PH_PREFIX  = 3'd2,
		PH_INT     = 3'd3,
		PH_FRAC    = 3'd4,
		PH_EXPSIGN = 3'd5,
		PH_EXPDIG  = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		RX_DEC = 2'd0,
		RX_HEX = 2'd1,
		RX_BIN = 2'd2,
		RX_OCT = 2'd3
	} radix_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_CHAR = 2'd1;
	localparam logic [1:0] ST_TOO_BIG  = 2'd2;

	localparam logic KIND_INT   = 1'b0;
	localparam logic KIND_FLOAT = 1'b1;

	localparam logic [DIG_WIDTH-1:0] DIG_NONE = 7'd99;

	localparam logic [CH_WIDTH-1:0] CH_ZERO   = 8'h30;
	localparam logic [CH_WIDTH-1:0] CH_NINE   = 8'h39;
	localparam logic [CH_WIDTH-1:0] CH_LC_A   = 8'h61;
	localparam logic [CH_WIDTH-1:0] CH_LC_Z   = 8'h7a;
	localparam logic [CH_WIDTH-1:0] CH_UC_A   = 8'h41;
	localparam logic [CH_WIDTH-1:0] CH_UC_Z   = 8'h5a;
	localparam logic [CH_WIDTH-1:0] CH_MINUS  = 8'h2d;
	localparam logic [CH_WIDTH-1:0] CH_PLUS   = 8'h2b;
	localparam logic [CH_WIDTH-1:0] CH_DOT    = 8'h2e;
	localparam logic [CH_WIDTH-1:0] CH_LC_X   = 8'h78;
	localparam logic [CH_WIDTH-1:0] CH_UC_X   = 8'h58;
	localparam logic [CH_WIDTH-1:0] CH_LC_B   = 8'h62;
	localparam logic [CH_WIDTH-1:0] CH_UC_B   = 8'h42;
	localparam logic [CH_WIDTH-1:0] CH_LC_E   = 8'h65;
	localparam logic [CH_WIDTH-1:0] CH_UC_E   = 8'h45;
	localparam logic [CH_WIDTH-1:0] CH_LC_P   = 8'h70;
	localparam logic [CH_WIDTH-1:0] CH_UC_P   = 8'h50;
	localparam logic [CH_WIDTH-1:0] CH_SPACE  = 8'h20;
	localparam logic [CH_WIDTH-1:0] CH_TAB    = 8'h09;
	localparam logic [CH_WIDTH-1:0] CH_CR     = 8'h0d;
	localparam logic [CH_WIDTH-1:0] CH_RPAREN = 8'h29;

	function automatic logic [DIG_WIDTH-1:0] digit_of(input logic [CH_WIDTH-1:0] c);
		logic [DIG_WIDTH-1:0] d;
		d = DIG_NONE;
		if (c >= CH_ZERO && c <= CH_NINE)
			d = DIG_WIDTH'(c - CH_ZERO);
		else if (c >= CH_LC_A && c <= CH_LC_Z)
			d = DIG_WIDTH'(c - CH_LC_A + 8'd10);
		else if (c >= CH_UC_A && c <= CH_UC_Z)
			d = DIG_WIDTH'(c - CH_UC_A + 8'd10);
		return d;
	endfunction

	function automatic logic [DIG_WIDTH-1:0] radix_base(input radix_t r);
		logic [DIG_WIDTH-1:0] b;
		case (r)
			RX_HEX:  b = 7'd16;
			RX_BIN:  b = 7'd2;
			RX_OCT:  b = 7'd8;
			default: b = 7'd10;
		endcase
		return b;
	endfunction

	function automatic logic is_exp_mark(input radix_t r, input logic [CH_WIDTH-1:0] c);
		logic m;
		case (r)
			RX_DEC:  m = (c == CH_LC_E) || (c == CH_UC_E);
			RX_HEX:  m = (c == CH_LC_P) || (c == CH_UC_P);
			default: m = 1'b0;
		endcase
		return m;
	endfunction

	function automatic logic is_ending(input logic eof, input logic [CH_WIDTH-1:0] c);
		return eof || (c == CH_SPACE) || (c == CH_RPAREN) || (c >= CH_TAB && c <= CH_CR);
	endfunction

endpackage

// ===== rtl/nlp_if.sv =====
// ----------------------------------------------------------------------------
// nlp interfaces
// valid/ready channels for token bytes and parse results
// ----------------------------------------------------------------------------
interface nlp_char_if;
	import nlp_pkg::*;

	logic                valid;
	logic                ready;
	logic [CH_WIDTH-1:0] ch;
	logic                at_eof;

	modport source (output valid, output ch, output at_eof, input ready);
	modport sink (input valid, input ch, input at_eof, output ready);
endinterface

interface nlp_result_if;
	import nlp_pkg::*;

	logic                        valid;
	logic                        ready;
	logic signed [OUT_WIDTH-1:0] int_value;
	logic                        kind;
	logic [1:0]                  status;

	modport source (output valid, output int_value, output kind, output status, input ready);
	modport sink (input valid, input int_value, input kind, input status, output ready);
endinterface

// ===== rtl/numeric_literal_parser.sv =====
// ----------------------------------------------------------------------------
// numeric_literal_parser
// byte-serial integer literal parser with sign, base prefix and float marking
// ----------------------------------------------------------------------------
// usage:
//   token carries one byte of a numeric literal per item (ch), or at_eof.
//   a byte that does not continue the literal ends it and yields one item
//   on result: int_value, kind (integer/float) and status (ok, bad char,
//   too big); bad char if that byte is not whitespace, ')' or at_eof.
//   bytes that continue it are absorbed and yield no item. an accepted byte
//   is registered in the input stage, its result in the output register.
//   throughput: one byte per cycle, save when a byte that ends a literal
//   waits on a held result; the limit is the combinational multiply-add
//   and overflow compare on the accumulator, whose update feeds the next byte.
//   stall: while result is held by the receiver, the input stage keeps a
//   byte that would end a literal and token.ready drops; bytes that
//   produce no item keep flowing.
//   reset: arst_n clears the parse state to the sign phase and empties both
//   stages; no clearing pass is needed.
// ----------------------------------------------------------------------------
module numeric_literal_parser #(
	parameter int VALUE_WIDTH = nlp_pkg::VALUE_WIDTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	nlp_char_if.sink     token,
	nlp_result_if.source result
);
	import nlp_pkg::*;

	localparam int PW = VALUE_WIDTH + 5;

	logic                   valid_s1;
	logic [CH_WIDTH-1:0]    ch_s1;
	logic                   eof_s1;

	phase_t                 phase_q, phase_n;
	radix_t                 radix_q, radix_n;
	logic                   neg_q, neg_n;
	logic [VALUE_WIDTH-1:0] acc_q, acc_n;
	logic                   ovf_q, ovf_n;
	logic                   flt_q, flt_n;

	logic                   out_valid_q;
	logic signed [OUT_WIDTH-1:0] out_value_q;
	logic                   out_kind_q;
	logic [1:0]             out_status_q;

	logic                   consumed;
	logic                   emit;
	logic                   advance;
	phase_t                 ph_e;
	radix_t                 rx_e;
	logic [DIG_WIDTH-1:0]   dig;
	logic [DIG_WIDTH-1:0]   base_e;
	logic                   is_sign;
	logic [PW-1:0]          acc_ext;
	logic [PW-1:0]          prod;
	logic [PW-1:0]          limit;

	logic signed [OUT_WIDTH-1:0] res_value;
	logic                   res_kind;
	logic [1:0]             res_status;
	logic signed [VALUE_WIDTH-1:0] sval;

	assign dig     = eof_s1 ? DIG_NONE : digit_of(ch_s1);
	assign is_sign = !eof_s1 && (ch_s1 == CH_PLUS || ch_s1 == CH_MINUS);
	assign acc_ext = PW'(acc_q);
	assign limit   = (PW'(1) << (VALUE_WIDTH - 1)) - PW'(!neg_q);

	// multiply by the constant base and add the digit
	always_comb begin
		case (rx_e)
			RX_HEX:  prod = (acc_ext << 4) + PW'(dig[3:0]);
			RX_BIN:  prod = (acc_ext << 1) + PW'(dig[3:0]);
			RX_OCT:  prod = (acc_ext << 3) + PW'(dig[3:0]);
			default: prod = (acc_ext << 3) + (acc_ext << 1) + PW'(dig[3:0]);
		endcase
	end

	assign base_e = radix_base(rx_e);

	// next state
	always_comb begin
		phase_n  = phase_q;
		radix_n  = radix_q;
		neg_n    = neg_q;
		acc_n    = acc_q;
		ovf_n    = ovf_q;
		flt_n    = flt_q;
		consumed = 1'b0;
		ph_e     = phase_q;
		rx_e     = radix_q;

		case (phase_q)
			PH_LEAD: begin
				if (!eof_s1 && ch_s1 == CH_ZERO) begin
					consumed = 1'b1;
					phase_n  = PH_PREFIX;
				end else begin
					ph_e = PH_INT;
				end
			end
			PH_PREFIX: begin
				ph_e    = PH_INT;
				phase_n = PH_INT;
				if (!eof_s1 && (ch_s1 == CH_LC_X || ch_s1 == CH_UC_X)) begin
					consumed = 1'b1;
					radix_n  = RX_HEX;
				end else if (!eof_s1 && (ch_s1 == CH_LC_B || ch_s1 == CH_UC_B)) begin
					consumed = 1'b1;
					radix_n  = RX_BIN;
				end else if (dig < 7'd10) begin
					rx_e = RX_OCT;
				end
			end
			PH_INT, PH_FRAC, PH_EXPDIG: begin
			end
			PH_EXPSIGN: begin
				phase_n = PH_EXPDIG;
				if (is_sign)
					consumed = 1'b1;
				else
					ph_e = PH_EXPDIG;
			end
			default: begin
				phase_n = PH_LEAD;
				if (is_sign) begin
					consumed = 1'b1;
					if (ch_s1 == CH_MINUS)
						neg_n = 1'b1;
				end else if (!eof_s1 && ch_s1 == CH_ZERO) begin
					consumed = 1'b1;
					phase_n  = PH_PREFIX;
				end else begin
					ph_e = PH_INT;
				end
			end
		endcase

		if (!consumed) begin
			radix_n = rx_e;
			phase_n = ph_e;
			case (ph_e)
				PH_INT: begin
					if (dig < base_e) begin
						consumed = 1'b1;
						if (!ovf_q) begin
							if (prod > limit)
								ovf_n = 1'b1;
							else
								acc_n = prod[VALUE_WIDTH-1:0];
						end
					end else if (!eof_s1 && ch_s1 == CH_DOT &&
					             (rx_e == RX_DEC || rx_e == RX_HEX)) begin
						consumed = 1'b1;
						flt_n    = 1'b1;
						phase_n  = PH_FRAC;
					end else if (!eof_s1 && is_exp_mark(rx_e, ch_s1)) begin
						consumed = 1'b1;
						flt_n    = 1'b1;
						phase_n  = PH_EXPSIGN;
					end
				end
				PH_FRAC: begin
					if (dig < base_e) begin
						consumed = 1'b1;
					end else if (!eof_s1 && is_exp_mark(rx_e, ch_s1)) begin
						consumed = 1'b1;
						phase_n  = PH_EXPSIGN;
					end
				end
				PH_EXPDIG: begin
					if (dig < 7'd10)
						consumed = 1'b1;
				end
				default: begin
				end
			endcase
		end

		// literal finished: back to a clean token
		if (!consumed) begin
			phase_n = PH_SIGN;
			radix_n = RX_DEC;
			neg_n   = 1'b0;
			acc_n   = '0;
			ovf_n   = 1'b0;
			flt_n   = 1'b0;
		end
	end

	assign emit = !consumed;

	// result fields
	always_comb begin
		sval       = neg_q ? -acc_q : acc_q;
		res_value  = '0;
		res_kind   = KIND_INT;
		res_status = ST_OK;
		if (!is_ending(eof_s1, ch_s1))
			res_status = ST_BAD_CHAR;
		else if (flt_q)
			res_kind = KIND_FLOAT;
		else if (ovf_q)
			res_status = ST_TOO_BIG;
		else
			res_value = OUT_WIDTH'(sval);
	end

	assign advance     = valid_s1 && (!emit || !out_valid_q || result.ready);
	assign token.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (token.ready) begin
			valid_s1 <= token.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (token.ready && token.valid) begin
			ch_s1  <= token.ch;
			eof_s1 <= token.at_eof;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIGN;
			radix_q <= RX_DEC;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			flt_q   <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_n;
			radix_q <= radix_n;
			neg_q   <= neg_n;
			acc_q   <= acc_n;
			ovf_q   <= ovf_n;
			flt_q   <= flt_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_value_q  <= res_value;
			out_kind_q   <= res_kind;
			out_status_q <= res_status;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.int_value = out_value_q;
	assign result.kind      = out_kind_q;
	assign result.status    = out_status_q;

endmodule

// ===== rtl/nlp_checker.sv =====
// ----------------------------------------------------------------------------
// nlp_checker
// port-level checks of the numeric literal parser, bound into numeric_literal_parser
// ----------------------------------------------------------------------------
`include "numeric_literal_parser_macros.svh"

module nlp_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  res_valid,
	input logic                                  res_ready,
	input logic signed [nlp_pkg::OUT_WIDTH-1:0]  res_value,
	input logic                                  res_kind,
	input logic [1:0]                            res_status
);
	import nlp_pkg::*;

	`NLP_ASSERT_HOLD(a_res_hold, clk, arst_n, res_valid, res_ready, res_value)

	`NLP_ASSERT(a_status_code, clk, arst_n, res_valid |-> res_status != 2'd3)

	`NLP_ASSERT(a_err_is_int, clk, arst_n, res_valid && res_status != ST_OK |-> res_kind == KIND_INT && res_value == '0)

	`NLP_ASSERT(a_float_no_value, clk, arst_n, res_valid && res_kind == KIND_FLOAT |-> res_status == ST_OK && res_value == '0)

endmodule

bind numeric_literal_parser nlp_checker u_nlp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_value  (result.int_value),
	.res_kind   (result.kind),
	.res_status (result.status)
);
